@@ hdl/puwm_pkg.sv @@
package puwm_pkg;

  localparam int IN_ROW_W    = 9;
  localparam int IN_COL_W    = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int OUT_W       = 17;
  localparam int OUT_TDATA_W = 40;
  localparam int TRIG_W      = 16;
  localparam int RAD_W       = 26;
  localparam int U_W         = 27;

  localparam int STAGES   = 7;
  localparam int STG_PROD = 0;
  localparam int STG_PART = 1;
  localparam int STG_QEST = 2;
  localparam int STG_QMUL = 3;
  localparam int STG_RAD  = 4;
  localparam int STG_MUL  = 5;
  localparam int STG_OUT  = 6;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  localparam logic signed [OUT_W-1:0] OUT_MIN = 17'sh10000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sh0FFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_R_MIN,
    REG_R_MAX,
    REG_CENTER_X,
    REG_CENTER_Y
  } cfg_reg_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
  } pipe_ctl_t;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [RAD_W-1:0]  radius_t;
  typedef logic signed [OUT_W-1:0]  coord_t;

endpackage

@@ hdl/puwm_angle.sv @@
module puwm_angle import puwm_pkg::*; #(
  parameter int OUT_COLS = 1200
) (
  input  logic                clk,
  input  pipe_ctl_t           ctl,
  input  logic [IN_COL_W-1:0] col,
  output trig_t               cos_v,
  output trig_t               sin_v
);

  localparam int COL_N = 1 << IN_COL_W;

  // Taylor term divisors, term n in slot n-1
  localparam logic [6:0][7:0] SIN_DIV = {8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [6:0][7:0] COS_DIV = {8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  function automatic longint to_q15(input longint v);
    longint r;
    if (v < 0) begin
      v = 0;
    end
    r = (v + 64'sd16384) >>> 15;
    return (r > 64'sd32767) ? 64'sd32767 : r;
  endfunction

  // {sin, cos} of -2*pi*col/OUT_COLS, Q1.15
  function automatic logic [2*TRIG_W-1:0] trig_entry(input int cidx);
    longint unsigned k, q, m, x, x2, st, ct;
    longint sa, ca, sq, cq, cosv, sinv;
    int n;
    k  = longint'(cidx) % OUT_COLS;
    q  = (4 * k) / OUT_COLS;
    m  = 4 * k - q * OUT_COLS;
    x  = (m * HALF_PI_Q30) / OUT_COLS;
    x2 = (x * x) >> 30;
    st = x;
    ct = ONE_Q30;
    sa = longint'(x);
    ca = longint'(ONE_Q30);
    for (n = 1; n <= 7; n++) begin
      st = ((st * x2) >> 30) / SIN_DIV[n-1];
      ct = ((ct * x2) >> 30) / COS_DIV[n-1];
      if ((n % 2) == 1) begin
        sa = sa - longint'(st);
        ca = ca - longint'(ct);
      end else begin
        sa = sa + longint'(st);
        ca = ca + longint'(ct);
      end
    end
    sq = to_q15(sa);
    cq = to_q15(ca);
    unique case (q)
      64'd0: begin
        cosv = cq;
        sinv = sq;
      end
      64'd1: begin
        cosv = -sq;
        sinv = cq;
      end
      64'd2: begin
        cosv = -cq;
        sinv = -sq;
      end
      default: begin
        cosv = sq;
        sinv = -cq;
      end
    endcase
    sinv = -sinv;
    return {TRIG_W'(sinv), TRIG_W'(cosv)};
  endfunction

  logic [2*TRIG_W-1:0] tbl   [COL_N];
  logic [2*TRIG_W-1:0] dly_r [STG_RAD+1];

  for (genvar g = 0; g < COL_N; g++) begin : g_tbl
    localparam logic [2*TRIG_W-1:0] ENTRY = trig_entry(g);
    assign tbl[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_PROD]) begin
      dly_r[STG_PROD] <= tbl[col];
    end
    for (int i = STG_PART; i <= STG_RAD; i++) begin
      if (ctl.load[i]) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign cos_v = dly_r[STG_RAD][TRIG_W-1:0];
  assign sin_v = dly_r[STG_RAD][2*TRIG_W-1:TRIG_W];

endmodule

@@ hdl/puwm_radius.sv @@
module puwm_radius import puwm_pkg::*; #(
  parameter int OUT_ROWS = 400
) (
  input  logic                clk,
  input  pipe_ctl_t           ctl,
  input  logic [CFG_W-1:0]    r_min,
  input  logic [CFG_W-1:0]    r_max,
  input  logic [IN_ROW_W-1:0] row,
  output radius_t             radius
);

  localparam int MAG_LIM = 1 << 25;
  localparam int OFS_B   = (MAG_LIM + OUT_ROWS - 1) / OUT_ROWS;
  localparam int OFFSET  = OFS_B * OUT_ROWS;
  localparam int RECIP   = (1 << U_W) / OUT_ROWS;
  localparam int DIV_W   = $clog2(OUT_ROWS + 1);
  localparam int RL_W    = U_W / 2;
  localparam int RH_W    = U_W - RL_W;
  localparam int PROD_W  = CFG_W + 1 + IN_ROW_W + 1;
  localparam int RS_W    = U_W + 2;

  localparam logic [U_W-1:0]   RECIP_V = U_W'(RECIP);
  localparam logic [DIV_W-1:0] DIV_V   = DIV_W'(OUT_ROWS);

  logic signed [CFG_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W:0]          biased;
  logic [2*U_W-1:0]         full;
  logic [U_W-1:0]           rem;
  logic [U_W-1:0]           qf;
  logic signed [RS_W-1:0]   rad;

  logic [U_W-1:0]      u_a_r, u_b_r, u_c_r, u_d_r;
  logic [U_W+RL_W-1:0] pl_r;
  logic [U_W+RH_W-1:0] ph_r;
  logic [U_W-1:0]      qe_c_r, qe_d_r, qd_d_r;
  radius_t             radius_r;

  // biased so the floor division works on a non-negative value
  assign diff   = signed'({1'b0, r_max}) - signed'({1'b0, r_min});
  assign prod   = diff * signed'({1'b0, row});
  assign biased = {prod[PROD_W-1], prod} + (PROD_W+1)'(OFFSET);

  assign full = {ph_r, RL_W'(0)} + (2*U_W)'(pl_r);

  assign rem = u_d_r - qd_d_r;
  assign qf  = qe_d_r + U_W'(rem >= U_W'(OUT_ROWS));
  assign rad = signed'(RS_W'(r_min)) + signed'(RS_W'(qf)) - signed'(RS_W'(OFS_B));

  always_ff @(posedge clk) begin
    if (ctl.load[STG_PROD]) begin
      u_a_r <= biased[U_W-1:0];
    end
    if (ctl.load[STG_PART]) begin
      pl_r  <= u_a_r * RECIP_V[RL_W-1:0];
      ph_r  <= u_a_r * RECIP_V[U_W-1:RL_W];
      u_b_r <= u_a_r;
    end
    if (ctl.load[STG_QEST]) begin
      qe_c_r <= full[2*U_W-1:U_W];
      u_c_r  <= u_b_r;
    end
    if (ctl.load[STG_QMUL]) begin
      qd_d_r <= U_W'(qe_c_r * DIV_V);
      qe_d_r <= qe_c_r;
      u_d_r  <= u_c_r;
    end
    if (ctl.load[STG_RAD]) begin
      radius_r <= rad[RAD_W-1:0];
    end
  end

  assign radius = radius_r;

endmodule

@@ hdl/puwm_project.sv @@
module puwm_project import puwm_pkg::*; (
  input  logic             clk,
  input  pipe_ctl_t        ctl,
  input  radius_t          radius,
  input  trig_t            cos_v,
  input  trig_t            sin_v,
  input  logic [CFG_W-1:0] center_x,
  input  logic [CFG_W-1:0] center_y,
  output coord_t           source_x,
  output coord_t           source_y
);

  localparam int PX_W  = RAD_W + TRIG_W;
  localparam int FX_W  = PX_W - 15;
  localparam int SUM_W = FX_W + 1;

  function automatic coord_t sat(input logic signed [SUM_W-1:0] v);
    coord_t r;
    priority if (v < SUM_W'(OUT_MIN)) begin
      r = OUT_MIN;
    end else if (v > SUM_W'(OUT_MAX)) begin
      r = OUT_MAX;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  logic signed [PX_W-1:0]  px_r, py_r;
  logic signed [FX_W-1:0]  fx, fy;
  logic signed [SUM_W-1:0] sx, sy;
  coord_t                  sx_r, sy_r;

  // dropping 15 bits of a signed product is the floor
  assign fx = px_r[PX_W-1:15];
  assign fy = py_r[PX_W-1:15];
  assign sx = signed'({fx[FX_W-1], fx}) + signed'(SUM_W'(center_x));
  assign sy = signed'({fy[FX_W-1], fy}) + signed'(SUM_W'(center_y));

  always_ff @(posedge clk) begin
    if (ctl.load[STG_MUL]) begin
      px_r <= radius * cos_v;
      py_r <= radius * sin_v;
    end
    if (ctl.load[STG_OUT]) begin
      sx_r <= sat(sx);
      sy_r <= sat(sy);
    end
  end

  assign source_x = sx_r;
  assign source_y = sy_r;

endmodule

@@ hdl/polar_unwarp_map_generator.sv @@
// Pipeline: 7 register stages from input to out_tvalid; one transaction per
// cycle while out_tready is high; every stage holds on a stall and the
// per-stage ready chain fills bubbles, so input is taken while a result waits.
// Reset (rst_n low, synchronous): all stage valid bits clear, r_min = 1920,
// r_max = 6400, center_x = center_y = 0. No clearing pass.
module polar_unwarp_map_generator import puwm_pkg::*; #(
  parameter int OUT_ROWS = 400,
  parameter int OUT_COLS = 1200
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [8:0] out_row, [19:9] out_column
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [16:0] source_x, [33:17] source_y
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic [CFG_W-1:0]  r_min_r, r_max_r, center_x_r, center_y_r;
  logic [STAGES-1:0] vld_r, vld_nxt, rdy;
  pipe_ctl_t         ctl;
  radius_t           radius;
  trig_t             cos_v, sin_v;
  coord_t            source_x, source_y;
  logic              in_acc, out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_min_r    <= CFG_W'(1920);
      r_max_r    <= CFG_W'(6400);
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_R_MIN:    r_min_r    <= cfg_wdata;
        REG_R_MAX:    r_max_r    <= cfg_wdata;
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        default:      r_min_r    <= r_min_r;
      endcase
    end
  end

  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int s = 1; s < STAGES; s++) begin
      vld_nxt[s] = rdy[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.load = rdy;

  puwm_radius #(
    .OUT_ROWS (OUT_ROWS)
  ) u_radius (
    .clk    (clk),
    .ctl    (ctl),
    .r_min  (r_min_r),
    .r_max  (r_max_r),
    .row    (in_tdata[IN_ROW_W-1:0]),
    .radius (radius)
  );

  puwm_angle #(
    .OUT_COLS (OUT_COLS)
  ) u_angle (
    .clk   (clk),
    .ctl   (ctl),
    .col   (in_tdata[IN_ROW_W+IN_COL_W-1:IN_ROW_W]),
    .cos_v (cos_v),
    .sin_v (sin_v)
  );

  puwm_project u_project (
    .clk      (clk),
    .ctl      (ctl),
    .radius   (radius),
    .cos_v    (cos_v),
    .sin_v    (sin_v),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .source_x (source_x),
    .source_y (source_y)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {(OUT_TDATA_W - 2*OUT_W)'(0), source_y, source_x};

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("input blocked while a pipeline stage is empty");

  a_count_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(vld_r) == $past($countones(vld_r))
      + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("transaction lost or duplicated in pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule
